// ===== src/kslp_pkg.sv =====
// Shared types and constants for the key short/long press detector.
package kslp_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WAIT  = 2'd1,
		PH_SHORT = 2'd2,
		PH_LONG  = 2'd3
	} phase_t;

	localparam int CNT_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] FILTER_TICKS_RST = 8'd20;
	localparam logic [CNT_W-1:0] LONG_TICKS_RST = 8'd50;
	localparam logic [CNT_W-1:0] HOLD_MAX = 8'hFF;

	localparam logic REQ_FILTER = 1'b0;
	localparam logic REQ_CLASSIFY = 1'b1;
	localparam logic LEVEL_PRESSED = 1'b0;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS = 2'd1;

	typedef struct packed {
		logic [CNT_W-1:0] filter_count;
		logic             filtered_pressed;
		logic [CNT_W-1:0] hold_count;
		phase_t           phase;
		logic             long_armed;
		logic             action_pending;
	} kslp_state_t;

	typedef struct packed {
		logic   short_press;
		logic   long_press;
		logic   release_done;
		logic   debounced_pressed;
		phase_t press_state;
	} kslp_result_t;

endpackage

// ===== src/key_short_long_press_detector_unit.sv =====
// Top level of the key short/long press detector.
//
// Input channel (in_valid/in_ready): one word per tick. req_type selects a
// filter tick, which samples key_level (0 = pressed), or a classify tick,
// which advances the hold counter and the press state.
// Output channel (out_valid/out_ready): exactly one result word per input
// word, in order: short_press, long_press, release_done (one-tick events,
// zero on filter ticks), debounced_pressed and press_state.
// The result of an accepted word is registered and shown from the cycle after
// it is accepted. Throughput is one word per cycle while the receiver takes
// each word, set by the single result register; state is updated as the word is accepted.
// When the receiver stalls, the result register holds its word and in_ready
// stays high only if that word is taken in the same cycle.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 filter_ticks, 1 long_ticks); other indexes are ignored.
// Reset (arst_n low) restores filter_ticks 20, long_ticks 50, the idle press
// state and an empty output register.
module key_short_long_press_detector_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic                              key_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              short_press,
	output logic                              long_press,
	output logic                              release_done,
	output logic                              debounced_pressed,
	output logic [1:0]                        press_state,
	input  logic                              cfg_we,
	input  logic [kslp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kslp_pkg::CNT_W-1:0]        cfg_data
);

	logic [kslp_pkg::CNT_W-1:0] filter_ticks_q;
	logic [kslp_pkg::CNT_W-1:0] long_ticks_q;
	kslp_pkg::kslp_state_t      st_q;
	kslp_pkg::kslp_state_t      st_next;
	kslp_pkg::kslp_result_t     res;
	kslp_pkg::kslp_result_t     res_q;
	logic                       out_valid_q;
	logic                       accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	kslp_core u_core (
		.req_type     (req_type),
		.key_level    (key_level),
		.filter_ticks (filter_ticks_q),
		.long_ticks   (long_ticks_q),
		.st           (st_q),
		.st_next      (st_next),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_ticks_q <= kslp_pkg::FILTER_TICKS_RST;
			long_ticks_q <= kslp_pkg::LONG_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kslp_pkg::CFG_FILTER_TICKS: filter_ticks_q <= cfg_data;
				kslp_pkg::CFG_LONG_TICKS:   long_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.filter_count <= kslp_pkg::FILTER_TICKS_RST;
			st_q.filtered_pressed <= 1'b0;
			st_q.hold_count <= '0;
			st_q.phase <= kslp_pkg::PH_IDLE;
			st_q.long_armed <= 1'b1;
			st_q.action_pending <= 1'b0;
		end else if (accept) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign short_press = res_q.short_press;
	assign long_press = res_q.long_press;
	assign release_done = res_q.release_done;
	assign debounced_pressed = res_q.debounced_pressed;
	assign press_state = res_q.press_state;

`ifndef SYNTHESIS
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({res_q.short_press, res_q.long_press, res_q.release_done}))
		else $error("more than one press event in a result word");

	a_filter_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == kslp_pkg::REQ_FILTER) |=>
		(out_valid_q && !res_q.short_press && !res_q.long_press && !res_q.release_done))
		else $error("press event on a filter tick");

	a_short_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.short_press) |-> (res_q.press_state == kslp_pkg::PH_SHORT))
		else $error("short press outside the short state");

	a_long_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.long_press) |->
		(res_q.press_state == kslp_pkg::PH_LONG && !st_q.long_armed))
		else $error("long press event without disarming");

	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (res_q.debounced_pressed == st_q.filtered_pressed &&
			res_q.press_state == st_q.phase))
		else $error("result word disagrees with the stored state");
`endif

endmodule

// ===== src/kslp_core.sv =====
// Next-state and result logic for one key word.
module kslp_core (
	input  logic                         req_type,
	input  logic                         key_level,
	input  logic [kslp_pkg::CNT_W-1:0]   filter_ticks,
	input  logic [kslp_pkg::CNT_W-1:0]   long_ticks,
	input  kslp_pkg::kslp_state_t        st,
	output kslp_pkg::kslp_state_t        st_next,
	output kslp_pkg::kslp_result_t       res
);

	always_comb begin
		logic [kslp_pkg::CNT_W-1:0] fc;
		logic [kslp_pkg::CNT_W-1:0] hc;
		st_next = st;
		res.short_press = 1'b0;
		res.long_press = 1'b0;
		res.release_done = 1'b0;
		fc = st.filter_count;
		hc = st.hold_count;
		if (req_type == kslp_pkg::REQ_FILTER) begin
			if (key_level == kslp_pkg::LEVEL_PRESSED) begin
				// Countdown holds at zero while the key stays down.
				if (fc != '0) begin
					fc = fc - 1'b1;
				end
				st_next.filter_count = fc;
				if (fc == '0) begin
					st_next.filtered_pressed = 1'b1;
				end
			end else begin
				st_next.filtered_pressed = 1'b0;
				st_next.filter_count = filter_ticks;
			end
		end else begin
			if (hc != kslp_pkg::HOLD_MAX) begin
				hc = hc + 1'b1;
			end
			if (st.filtered_pressed && (hc > long_ticks)) begin
				st_next.hold_count = long_ticks;
				st_next.phase = kslp_pkg::PH_LONG;
			end else if (st.filtered_pressed) begin
				st_next.hold_count = hc;
				st_next.phase = kslp_pkg::PH_WAIT;
			end else begin
				st_next.hold_count = '0;
				st_next.phase = (st.phase == kslp_pkg::PH_WAIT) ?
					kslp_pkg::PH_SHORT : kslp_pkg::PH_IDLE;
				st_next.long_armed = 1'b1;
			end

			if (st_next.phase == kslp_pkg::PH_SHORT) begin
				st_next.action_pending = 1'b1;
				res.short_press = 1'b1;
			end else if (st_next.phase == kslp_pkg::PH_LONG && st_next.long_armed) begin
				st_next.long_armed = 1'b0;
				st_next.action_pending = 1'b1;
				res.long_press = 1'b1;
			end else if (st_next.phase == kslp_pkg::PH_IDLE && st.action_pending) begin
				st_next.action_pending = 1'b0;
				res.release_done = 1'b1;
			end
		end
		res.debounced_pressed = st_next.filtered_pressed;
		res.press_state = st_next.phase;
	end

endmodule
